>>> design/lwma_pkg.sv
// Shared types, constants and state encoding for the weighted moving average unit.
package lwma_pkg;

  localparam int MAX_PERIOD_DEF = 64;
  localparam int PRICE_W        = 32;
  localparam int DATE_W         = 32;
  localparam int PERIOD_W       = 7;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 7'd10;

  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  // register index codes (paddr[2])
  localparam logic REG_PERIOD = 1'b0;

  typedef struct packed {
    logic [PRICE_W-1:0] close_price;
    logic [DATE_W-1:0]  bar_date;
    logic               restart;
  } in_item_t;

  typedef struct packed {
    logic [PRICE_W-1:0] average;
    logic [DATE_W-1:0]  date_out;
    logic               valid_res;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACCUM,
    ST_DIVIDE,
    ST_DONE
  } state_t;

endpackage

>>> design/weighted_moving_average_unit.sv
// Top level: linear weighted moving average over a circular window of prices.
// Each price transaction is taken in ST_IDLE and written into the window.
// While fewer than period prices have arrived since the last restart, the
// result (valid_res 0, average 0) is loaded straight from ST_DONE. Otherwise a
// sequencer walks the window from newest to oldest, one tap per cycle through
// the memory read port and a shared 32 x 7 multiply-accumulate, then a serial
// divider produces one quotient bit per cycle. The price input stalls until
// the result is placed in the output register, which may still wait while the
// next price is taken. period is written over APB at address 0; 0 acts as 1
// and values above MAX_PERIOD act as MAX_PERIOD.
module weighted_moving_average_unit #(
  parameter int MAX_PERIOD = lwma_pkg::MAX_PERIOD_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          price_valid,
  output logic                          price_stall,
  input  lwma_pkg::in_item_t            price_item,
  output logic                          result_valid,
  input  logic                          result_stall,
  output lwma_pkg::out_item_t           result_item,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lwma_pkg::APB_AW-1:0]   paddr,
  input  logic [lwma_pkg::APB_DW-1:0]   pwdata,
  output logic [lwma_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);
  import lwma_pkg::*;

  localparam int AW      = (MAX_PERIOD > 1) ? $clog2(MAX_PERIOD) : 1;
  localparam int CW      = $clog2(MAX_PERIOD + 1);
  localparam int DEN_W   = $clog2(MAX_PERIOD * (MAX_PERIOD + 1) / 2 + 1);
  localparam int ACC_W   = PRICE_W + DEN_W;
  localparam int PROD_W  = PRICE_W + CW;
  localparam int DP_W    = 2 * CW + 1;
  localparam int EXT_W   = (CW > PERIOD_W) ? CW : PERIOD_W;

  state_t state, state_next;

  logic [PERIOD_W-1:0] period;
  logic [AW-1:0]       write_slot;
  logic [CW-1:0]       fill_count;

  logic [CW-1:0]       pe;
  logic                item_valid;
  logic [DATE_W-1:0]   item_date;

  logic [AW-1:0]       raddr;
  logic [CW-1:0]       weight;
  logic                tv1, tv2;
  logic [CW-1:0]       wt1;
  logic [PROD_W-1:0]   prod;
  logic [ACC_W-1:0]    acc;
  logic [PRICE_W-1:0]  rdata;

  logic                div_done;
  logic [PRICE_W-1:0]  quotient;
  logic [DEN_W-1:0]    den;
  logic [DP_W-1:0]     den_prod;

  logic                accept, issue, accum_done, div_start, out_load, cfg_wr;
  logic [EXT_W-1:0]    period_ext;
  logic [CW-1:0]       p_eff;
  logic [CW-1:0]       fill_base, fill_new;
  logic                valid_new;

  // ---------------- configuration ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_PERIOD);

  always_ff @(posedge clk) begin
    if (rst) begin
      period <= PERIOD_RESET;
    end else if (cfg_wr) begin
      period <= pwdata[PERIOD_W-1:0];
    end
  end

  always_comb begin
    if (paddr[2] == REG_PERIOD) begin
      prdata = APB_DW'(period);
    end else begin
      prdata = '0;
    end
  end

  // ---------------- per-item bookkeeping ----------------
  always_comb begin
    period_ext = EXT_W'(period);
    if (period_ext == '0) begin
      p_eff = CW'(1);
    end else if (period_ext > EXT_W'(MAX_PERIOD)) begin
      p_eff = CW'(MAX_PERIOD);
    end else begin
      p_eff = CW'(period_ext);
    end
    fill_base = price_item.restart ? '0 : fill_count;
    fill_new  = (fill_base < CW'(MAX_PERIOD)) ? (fill_base + CW'(1)) : fill_base;
    valid_new = (fill_new >= p_eff);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot <= '0;
      fill_count <= '0;
    end else if (accept) begin
      write_slot <= (write_slot == AW'(MAX_PERIOD - 1)) ? '0 : (write_slot + AW'(1));
      fill_count <= fill_new;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pe         <= p_eff;
      item_valid <= valid_new;
      item_date  <= price_item.bar_date;
    end
  end

  // ---------------- sequencer ----------------
  assign accum_done = (weight == '0) && !tv1 && !tv2;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (price_valid) state_next = valid_new ? ST_ACCUM : ST_DONE;
      ST_ACCUM:  if (accum_done) state_next = ST_DIVIDE;
      ST_DIVIDE: if (div_done) state_next = ST_DONE;
      ST_DONE:   if (!result_valid || !result_stall) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    price_stall = 1'b1;
    accept      = 1'b0;
    issue       = 1'b0;
    div_start   = 1'b0;
    out_load    = 1'b0;
    case (state)
      ST_IDLE: begin
        price_stall = 1'b0;
        accept      = price_valid;
      end
      ST_ACCUM: begin
        issue     = (weight != '0);
        div_start = accum_done;
      end
      ST_DIVIDE: ;
      ST_DONE:  out_load = !result_valid || !result_stall;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // ---------------- window walk and multiply-accumulate ----------------
  lwma_window_mem #(
    .DEPTH (MAX_PERIOD),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (accept),
    .wr_addr (write_slot),
    .wr_data (price_item.close_price),
    .rd_en   (issue),
    .rd_addr (raddr),
    .rd_data (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      weight <= '0;
      tv1    <= 1'b0;
      tv2    <= 1'b0;
    end else begin
      tv1 <= issue;
      tv2 <= tv1;
      if (accept && valid_new) begin
        weight <= p_eff;
      end else if (issue) begin
        weight <= weight - CW'(1);
      end
    end
  end

  // newest tap first, weight falling from period to 1
  always_ff @(posedge clk) begin
    if (accept) begin
      raddr <= write_slot;
      acc   <= '0;
    end else begin
      if (issue) begin
        raddr <= (raddr == '0) ? AW'(MAX_PERIOD - 1) : (raddr - AW'(1));
      end
      if (tv2) begin
        acc <= acc + ACC_W'(prod);
      end
    end
    wt1  <= weight;
    prod <= PROD_W'(rdata) * PROD_W'(wt1);
  end

  // ---------------- division ----------------
  assign den_prod = DP_W'(pe) * (DP_W'(pe) + DP_W'(1));
  assign den      = DEN_W'(den_prod >> 1);

  lwma_divider #(
    .DEN_W (DEN_W),
    .ACC_W (ACC_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (acc),
    .divisor  (den),
    .done     (div_done),
    .quotient (quotient)
  );

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result_item.average   <= item_valid ? quotient : '0;
      result_item.date_out  <= item_date;
      result_item.valid_res <= item_valid;
    end
  end

  // ---------------- checks ----------------
  a_avg_zero_when_invalid: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_item.valid_res) |-> (result_item.average == '0))
    else $error("average nonzero on an invalid result");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= CW'(MAX_PERIOD))
    else $error("fill count above window depth");

  a_div_done_in_divide: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_DIVIDE))
    else $error("divider finished outside divide phase");

endmodule

>>> design/lwma_window_mem.sv
// Price window memory: one write port, one registered read port.
module lwma_window_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [AW-1:0]                wr_addr,
  input  logic [lwma_pkg::PRICE_W-1:0] wr_data,
  input  logic                         rd_en,
  input  logic [AW-1:0]                rd_addr,
  output logic [lwma_pkg::PRICE_W-1:0] rd_data
);
  import lwma_pkg::*;

  logic [PRICE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> design/lwma_divider.sv
// Restoring serial divider: one quotient bit per cycle, PRICE_W-bit quotient.
module lwma_divider #(
  parameter int DEN_W = 12,
  parameter int ACC_W = 44
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [ACC_W-1:0]             dividend,
  input  logic [DEN_W-1:0]             divisor,
  output logic                         done,
  output logic [lwma_pkg::PRICE_W-1:0] quotient
);
  import lwma_pkg::*;

  localparam int CNT_W = (PRICE_W > 1) ? $clog2(PRICE_W) : 1;

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W:0]   rem;
  logic [DEN_W-1:0] den;
  logic [DEN_W:0]   shifted;
  logic [DEN_W:0]   rem_next;
  logic             qbit;

  // low dividend bits shift out of the top of quotient as result bits shift in
  always_comb begin
    shifted  = {rem[DEN_W-1:0], quotient[PRICE_W-1]};
    qbit     = (shifted >= {1'b0, den});
    rem_next = qbit ? (shifted - {1'b0, den}) : shifted;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(PRICE_W - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= {1'b0, dividend[ACC_W-1:PRICE_W]};
      quotient <= dividend[PRICE_W-1:0];
      den      <= divisor;
    end else if (busy) begin
      rem      <= rem_next;
      quotient <= {quotient[PRICE_W-2:0], qbit};
    end
  end

  // quotient fits PRICE_W bits only if the partial remainder stays below the divisor
  a_rem_below_den: assert property (@(posedge clk) disable iff (rst)
    busy |-> (rem < {1'b0, den}))
    else $error("divider remainder not below divisor");

endmodule

>>> tb/weighted_moving_average_unit_test.sv
// Self-checking testbench for the weighted moving average unit.
`timescale 1ns / 100ps

module weighted_moving_average_unit_test;
  import lwma_pkg::*;

  localparam int WINDOW_DEPTH  = MAX_PERIOD_DEF;
  localparam int QUIET_LIMIT   = 5000;
  localparam int DRAIN_CYCLES  = 150;
  localparam int HOLD_CYCLES   = 600;
  localparam int PHASE_ITEMS   = 125;
  localparam int NUM_PHASES    = 12;
  localparam int RANDOM_PERIOD = 255;
  localparam int PHASE_PERIOD [NUM_PHASES] =
    '{64, 5, 127, 1, 0, 33, 100, 2, RANDOM_PERIOD, RANDOM_PERIOD, 64, 17};

  class lwma_scoreboard;
    logic [PRICE_W-1:0]  price_window [WINDOW_DEPTH];
    int unsigned         slot_ptr;
    int unsigned         series_len;
    logic [PERIOD_W-1:0] period_reg;
    out_item_t           expected_averages [$];
    int unsigned         mismatch_count;

    function new();
      foreach (price_window[i]) price_window[i] = '0;
      slot_ptr       = 0;
      series_len     = 0;
      period_reg     = PERIOD_RESET;
      mismatch_count = 0;
    endfunction

    // 0 acts as 1, anything above the window depth saturates
    function int unsigned window_len();
      int unsigned p;
      p = period_reg;
      if (p < 1) p = 1;
      if (p > WINDOW_DEPTH) p = WINDOW_DEPTH;
      return p;
    endfunction

    function void set_period(logic [APB_DW-1:0] value);
      period_reg = value[PERIOD_W-1:0];
    endfunction

    function void note_price(in_item_t item);
      int unsigned p;
      int unsigned newest;
      int unsigned slot;
      int unsigned k;
      logic [63:0] tap_total;
      logic [63:0] divisor;
      out_item_t   want;
      p = window_len();
      if (item.restart) series_len = 0;
      newest = slot_ptr;
      price_window[newest] = item.close_price;
      slot_ptr = (newest + 1) % WINDOW_DEPTH;
      if (series_len < WINDOW_DEPTH) series_len++;
      want.date_out  = item.bar_date;
      want.valid_res = (series_len >= p);
      want.average   = '0;
      if (want.valid_res) begin
        tap_total = '0;
        // newest tap carries weight p, oldest weight 1
        for (k = 0; k < p; k++) begin
          slot = (newest + WINDOW_DEPTH - k) % WINDOW_DEPTH;
          tap_total += 64'(price_window[slot]) * 64'(p - k);
        end
        divisor = (64'(p) * 64'(p + 1)) / 2;
        want.average = 32'(tap_total / divisor);
      end
      expected_averages.push_back(want);
    endfunction

    function void check_average(out_item_t got);
      out_item_t want;
      if (expected_averages.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: unexpected result: average %h date %h valid %b",
                   $time, got.average, got.date_out, got.valid_res);
        return;
      end
      want = expected_averages.pop_front();
      if (got.average !== want.average || got.date_out !== want.date_out ||
          got.valid_res !== want.valid_res) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: mismatch: average exp %h got %h, date exp %h got %h, valid exp %b got %b",
                   $time, want.average, got.average, want.date_out, got.date_out,
                   want.valid_res, got.valid_res);
      end
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic                price_valid;
  logic                price_stall;
  in_item_t            price_item;
  logic                result_valid;
  logic                result_stall;
  out_item_t           result_item;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [APB_AW-1:0]   paddr;
  logic [APB_DW-1:0]   pwdata;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  lwma_scoreboard sb;
  int send_idle_pct;
  int stall_pct;
  int hold_left;
  int quiet_cycles;

  weighted_moving_average_unit dut (
    .clk          (clk),
    .rst          (rst),
    .price_valid  (price_valid),
    .price_stall  (price_stall),
    .price_item   (price_item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_item  (result_item),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver: random stalls, plus a long hold-off when requested
  initial begin
    result_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        result_stall = 1'b1;
        hold_left--;
      end else begin
        result_stall = (stall_pct != 0) && ($urandom_range(99) < stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid && !result_stall) sb.check_average(result_item);
      if ((price_valid && !price_stall) || (result_valid && !result_stall))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task send_price(input in_item_t item);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      price_valid = 1'b0;
      @(negedge clk);
    end
    price_item  = item;
    price_valid = 1'b1;
    @(posedge clk);
    while (price_stall) @(posedge clk);
    sb.note_price(item);
    @(negedge clk);
    // a following send in the same step raises valid again with no gap
    price_valid = 1'b0;
  endtask

  task send_fields(input logic [PRICE_W-1:0] price, input logic restart);
    in_item_t item;
    item.close_price = price;
    item.bar_date    = $urandom;
    item.restart     = restart;
    send_price(item);
  endtask

  task wait_drained();
    while (sb.expected_averages.size() != 0) @(negedge clk);
  endtask

  // upper data bits are random; only the low period bits land in the register
  task write_period(input logic [PERIOD_W-1:0] value);
    logic [APB_DW-1:0] word;
    word = $urandom;
    word[PERIOD_W-1:0] = value;
    @(negedge clk);
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = {REG_PERIOD, 2'b00};
    pwdata  = word;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.set_period(word);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  function automatic in_item_t random_price(int unsigned restart_odds);
    in_item_t item;
    case ($urandom_range(7))
      0:       item.close_price = '0;
      1:       item.close_price = '1;
      2:       item.close_price = $urandom_range(255);
      default: item.close_price = $urandom;
    endcase
    item.bar_date = $urandom;
    item.restart  = ($urandom_range(restart_odds - 1) == 0);
    return item;
  endfunction

  initial begin
    int unsigned restart_odds;
    int          period_val;
    int          i;
    int          ph;
    sb            = new();
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_left     = 0;
    quiet_cycles  = 0;
    rst           = 1'b1;
    price_valid   = 1'b0;
    price_item    = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset period: full-scale window, then a zero price and a 32'h0001_0000 price
    for (i = 0; i < 12; i++) begin
      if (i < 10) send_fields('1, 1'b0);
      else if (i == 10) send_fields('0, 1'b0);
      else send_fields(32'h0001_0000, 1'b0);
    end
    wait_drained();
    write_period(7'd1);
    send_fields('1, 1'b1);
    send_fields('0, 1'b0);
    send_fields(32'h1234_5678, 1'b1);
    wait_drained();
    write_period(7'd0);
    send_fields('1, 1'b0);
    send_fields(32'd1, 1'b1);
    wait_drained();
    write_period(7'd2);
    send_fields(32'd5, 1'b0);
    send_fields(32'd7, 1'b1);
    send_fields(32'd9, 1'b0);
    send_fields(32'd11, 1'b0);
    // period grows mid-series, no restart
    wait_drained();
    write_period(7'd3);
    send_fields(32'hFFFF_0000, 1'b0);
    send_fields(32'h0000_FFFF, 1'b0);

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      wait_drained();
      period_val = PHASE_PERIOD[ph];
      if (period_val == RANDOM_PERIOD) period_val = $urandom_range(127);
      write_period(period_val[PERIOD_W-1:0]);
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 87; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 87; end
        default: begin send_idle_pct = 24; stall_pct = 24; end
      endcase
      // mostly long series so the window fills; a couple of phases restart often
      if (ph == 7 || ph == 11) restart_odds = 3;
      else restart_odds = 4 * sb.window_len() + 8;
      for (i = 0; i < PHASE_ITEMS; i++) begin
        if (ph == 3 && i == 10) hold_left = HOLD_CYCLES;
        if (i == PHASE_ITEMS / 2) begin
          price_valid = 1'b0;
          wait_drained();
        end
        send_price(random_price(restart_odds));
      end
    end

    price_valid = 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatch_count == 0 && sb.expected_averages.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
